// ----- rtl/csfd_pkg.sv -----
// ----------------------------------------------------------------------------
// csfd_pkg
// Shared types and constants for the special-instruction flag datapath.
// ----------------------------------------------------------------------------
package csfd_pkg;

  typedef enum logic [2:0] {
    CMD_DAA  = 3'd0,
    CMD_CPI  = 3'd1,
    CMD_CPD  = 3'd2,
    CMD_OUTI = 3'd3,
    CMD_OUTD = 3'd4,
    CMD_INI  = 3'd5,
    CMD_IND  = 3'd6
  } cmd_t;

  // Low-nibble and high-nibble decimal correction
  localparam logic [7:0] DAA_FIX   = 8'h06;
  localparam logic [7:0] DAA_LIMIT = 8'h09;

  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  acc;
    logic [7:0]  flags;
    logic [15:0] pair_bc;
    logic [15:0] pair_hl;
    logic [7:0]  data_byte;
  } csfd_item_t;

  typedef struct packed {
    logic [7:0]  acc;
    logic [7:0]  flags;
    logic [15:0] pair_bc;
    logic [15:0] pair_hl;
    logic [15:0] port_address;
  } csfd_result_t;

endpackage

// ----- rtl/csfd_exec.sv -----
// ----------------------------------------------------------------------------
// csfd_exec
// Flag and register update for DAA, CPI/CPD and OUTI/OUTD/INI/IND.
// ----------------------------------------------------------------------------
module csfd_exec (
  input  csfd_pkg::csfd_item_t   item,
  output csfd_pkg::csfd_result_t res
);
  import csfd_pkg::*;

  logic [7:0]  a;
  logic [7:0]  d;
  logic [7:0]  f;
  // decimal adjust
  logic        cy;
  logic        hc;
  logic        sub;
  logic [7:0]  lo8;
  logic [7:0]  hi8;
  logic [7:0]  daa_a;
  // compare
  logic [7:0]  cmp_res;
  logic        cmp_h;
  logic [7:0]  cmp_t;
  logic [15:0] bc_dec;
  // block I/O
  logic [7:0]  newb;
  logic [15:0] hl_inc;
  logic [15:0] hl_dec;
  logic [7:0]  io_k;
  logic [8:0]  io_sum;
  logic [7:0]  io_flags;

  assign a = item.acc;
  assign d = item.data_byte;
  assign f = item.flags;

  always_comb begin
    cy  = f[0];
    hc  = f[4];
    sub = f[1];
    lo8 = {4'b0, a[3:0]};
    hi8 = {4'b0, a[7:4]};
    if (lo8 > DAA_LIMIT || hc) begin
      if (!sub) begin
        lo8 = lo8 + DAA_FIX;
        if (lo8 >= 8'h10) begin
          lo8 = lo8 & 8'h0F;
          hi8 = hi8 + 8'd1;
          hc  = 1'b1;
        end else begin
          hc = 1'b0;
        end
      end else begin
        if (lo8 > DAA_LIMIT && hi8 >= DAA_LIMIT) cy = 1'b1;
        // borrow out of the low nibble shows up in bit 4
        lo8 = lo8 - DAA_FIX;
        hc  = lo8[4];
      end
    end else begin
      hc = 1'b0;
    end
    if (hi8 > DAA_LIMIT || cy) begin
      if (!sub) begin
        hi8 = hi8 + DAA_FIX;
        if (hi8 >= 8'h10) cy = 1'b1;
      end else begin
        if (hi8 > DAA_LIMIT) cy = 1'b1;
        hi8 = hi8 - DAA_FIX;
      end
    end
    daa_a = {hi8[3:0], 4'b0} + lo8;
  end

  assign cmp_res = a - d;
  assign cmp_h   = a[4] ^ d[4] ^ cmp_res[4];
  assign cmp_t   = cmp_res - {7'b0, cmp_h};
  assign bc_dec  = item.pair_bc - 16'd1;

  assign newb   = item.pair_bc[15:8] - 8'd1;
  assign hl_inc = item.pair_hl + 16'd1;
  assign hl_dec = item.pair_hl - 16'd1;

  always_comb begin
    case (item.command)
      CMD_OUTI: io_k = hl_inc[7:0];
      CMD_OUTD: io_k = hl_dec[7:0];
      CMD_INI:  io_k = item.pair_bc[7:0] + 8'd1;
      default:  io_k = item.pair_bc[7:0] - 8'd1;
    endcase
  end

  assign io_sum   = {1'b0, d} + {1'b0, io_k};
  assign io_flags = {newb[7], newb == 8'h00, newb[5], io_sum[8], newb[3],
                     ~^({5'b0, io_sum[2:0]} ^ newb), d[7], io_sum[8]};

  always_comb begin
    res.acc          = a;
    res.flags        = f;
    res.pair_bc      = item.pair_bc;
    res.pair_hl      = item.pair_hl;
    res.port_address = 16'h0000;
    case (item.command)
      CMD_DAA: begin
        res.acc   = daa_a;
        res.flags = {daa_a[7], daa_a == 8'h00, daa_a[5], hc, daa_a[3],
                     ~^daa_a, sub, cy};
      end
      CMD_CPI, CMD_CPD: begin
        res.pair_bc = bc_dec;
        res.pair_hl = (item.command == CMD_CPI) ? hl_inc : hl_dec;
        res.flags   = {cmp_res[7], cmp_res == 8'h00, cmp_t[1], cmp_h, cmp_t[3],
                       bc_dec != 16'h0000, 1'b1, f[0]};
      end
      CMD_OUTI, CMD_OUTD: begin
        res.pair_bc      = {newb, item.pair_bc[7:0]};
        res.pair_hl      = (item.command == CMD_OUTI) ? hl_inc : hl_dec;
        res.flags        = io_flags;
        res.port_address = {newb, item.pair_bc[7:0]};
      end
      CMD_INI, CMD_IND: begin
        res.pair_bc      = {newb, item.pair_bc[7:0]};
        res.pair_hl      = (item.command == CMD_INI) ? hl_inc : hl_dec;
        res.flags        = io_flags;
        res.port_address = item.pair_bc;
      end
      default: begin
        // unused code: pass registers through
        res.port_address = 16'h0000;
      end
    endcase
  end

endmodule

// ----- rtl/cpu_special_flag_datapath_top.sv -----
// ----------------------------------------------------------------------------
// cpu_special_flag_datapath_top
// Registered flag datapath for DAA, block compares and block I/O.
// ----------------------------------------------------------------------------
// Path: an accepted item passes the input register, then the result register,
//   before out_valid rises; a stall on out_ready holds it in place.
// Throughput: one item per cycle unless out_ready stalls; the two register stages
//   advance together whenever the result register is empty or being taken.
// Reset: rst_n low clears both stage valid bits; payload is not reset.
module cpu_special_flag_datapath_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_command,
  input  logic [7:0]  in_acc_in,
  input  logic [7:0]  in_flags_in,
  input  logic [15:0] in_pair_bc_in,
  input  logic [15:0] in_pair_hl_in,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_acc_out,
  output logic [7:0]  out_flags_out,
  output logic [15:0] out_pair_bc_out,
  output logic [15:0] out_pair_hl_out,
  output logic [15:0] out_port_address
);
  import csfd_pkg::*;

  csfd_item_t   s1_item_r;
  logic         s1_v_r;
  logic         s1_v_nxt;
  csfd_result_t exec_res;
  csfd_result_t out_res_r;
  logic         out_v_r;
  logic         out_v_nxt;
  logic         s1_adv;
  logic         in_xfer;

  assign s1_adv   = !out_v_r || out_ready;
  assign in_ready = !s1_v_r || s1_adv;
  assign in_xfer  = in_valid && in_ready;

  assign s1_v_nxt  = in_xfer ? 1'b1 : (s1_adv ? 1'b0 : s1_v_r);
  assign out_v_nxt = s1_adv ? s1_v_r : out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r <= '{command:   in_command,
                     acc:       in_acc_in,
                     flags:     in_flags_in,
                     pair_bc:   in_pair_bc_in,
                     pair_hl:   in_pair_hl_in,
                     data_byte: in_data_byte};
    end
    // hold the result while the consumer stalls
    if (s1_adv && s1_v_r) begin
      out_res_r <= exec_res;
    end
  end

  csfd_exec u_exec (
    .item (s1_item_r),
    .res  (exec_res)
  );

  assign out_valid        = out_v_r;
  assign out_acc_out      = out_res_r.acc;
  assign out_flags_out    = out_res_r.flags;
  assign out_pair_bc_out  = out_res_r.pair_bc;
  assign out_pair_hl_out  = out_res_r.pair_hl;
  assign out_port_address = out_res_r.port_address;

  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> s1_v_r)
    else $error("accepted transfer did not reach the input register");

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s1_adv |=> s1_v_r && $stable(s1_item_r))
    else $error("stalled input register lost its item");

  a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && s1_adv |=> out_valid)
    else $error("advancing item did not reach the result register");

  a_daa_port: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && s1_adv && s1_item_r.command == CMD_DAA
      |=> out_port_address == 16'h0000 && out_pair_bc_out == $past(s1_item_r.pair_bc))
    else $error("decimal adjust disturbed BC or the port address");

endmodule
